/* src/gemv_pkg.sv */
package gemv_pkg;

  localparam int FIELD_LANES = 8;
  localparam int ACT_W       = 8;
  localparam int WGT_W       = 4;
  localparam int SCALE_W     = 16;
  localparam int PART_W      = 18;
  localparam int ACC_W       = 48;
  localparam int ROWS_W      = 16;
  localparam int CFG_INDEX_W = 1;

  localparam logic [CFG_INDEX_W-1:0] REG_ACTIVATION_SCALE = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ROWS_IN_PASS     = 1'd1;

  typedef struct packed {
    logic                             row_last;
    logic [SCALE_W-1:0]               group_scale;
    logic [FIELD_LANES*WGT_W-1:0]     weight_nibbles;
    logic [FIELD_LANES*ACT_W-1:0]     activation_lanes;
  } gemv_in_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] channel_value;
    logic                    saturated;
    logic                    pass_last;
  } gemv_out_t;

  typedef struct packed {
    logic load;   // take the input request, update group partial
    logic gmul;   // partial times group scale
    logic gacc;   // add group product into row accumulator
    logic mlo;    // low half of accumulator times activation scale
    logic mhi;    // high half of accumulator times activation scale
    logic fin;    // combine, shift, clip, write output register
  } gemv_cmd_t;

  typedef struct packed {
    logic close;     // current request closes its group
    logic last;      // request being finished closes the row
    logic out_free;  // output register can take a new result
  } gemv_status_t;

endpackage

/* src/gemv_ctrl.sv */
module gemv_ctrl
  import gemv_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_stall,
  input  gemv_status_t status,
  output gemv_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_GMUL = 3'd1;
  localparam logic [2:0] S_GACC = 3'd2;
  localparam logic [2:0] S_MLO  = 3'd3;
  localparam logic [2:0] S_MHI  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_stall = rst || (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (status.close) state_next = S_GMUL;
        end
      end
      S_GMUL: begin
        cmd.gmul   = 1'b1;
        state_next = S_GACC;
      end
      S_GACC: begin
        cmd.gacc   = 1'b1;
        state_next = status.last ? S_MLO : S_IDLE;
      end
      S_MLO: begin
        cmd.mlo    = 1'b1;
        state_next = S_MHI;
      end
      S_MHI: begin
        cmd.mhi    = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        // hold here until the previous result has been taken
        if (status.out_free) begin
          cmd.fin    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* src/gemv_datapath.sv */
module gemv_datapath
  import gemv_pkg::*;
#(
  parameter int LANES           = 8,
  parameter int GROUP_SIZE      = 32,
  parameter int SCALE_FRAC_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [SCALE_W-1:0]     cfg_data,
  input  gemv_in_t               in_item,
  output gemv_out_t              out_item,
  output logic                   out_valid,
  input  logic                   out_stall,
  input  gemv_cmd_t              cmd,
  output gemv_status_t           status
);

  localparam int ITEMS_PER_GROUP = (GROUP_SIZE / LANES > 0) ? GROUP_SIZE / LANES : 1;
  localparam int CNT_W           = (ITEMS_PER_GROUP > 1) ? $clog2(ITEMS_PER_GROUP) : 1;
  localparam int USED_LANES      = (LANES < FIELD_LANES) ? LANES : FIELD_LANES;
  localparam int PROD_W          = ACT_W + WGT_W;
  localparam int DOT_W           = 16;
  localparam int GPROD_W         = PART_W + SCALE_W + 1;
  localparam int HALF_W          = ACC_W / 2;
  localparam int PLO_W           = HALF_W + SCALE_W;
  localparam int FULL_W          = ACC_W + SCALE_W;

  localparam logic signed [PART_W-1:0] PART_MAX = {1'b0, {(PART_W-1){1'b1}}};
  localparam logic signed [PART_W-1:0] PART_MIN = {1'b1, {(PART_W-1){1'b0}}};
  localparam logic signed [ACC_W-1:0]  ACC_MAX  = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0]  ACC_MIN  = {1'b1, {(ACC_W-1){1'b0}}};

  // configuration
  logic [SCALE_W-1:0] activation_scale;
  logic [ROWS_W-1:0]  rows_in_pass;

  // row state
  logic signed [PART_W-1:0]  group_partial;
  logic [CNT_W-1:0]          items_in_group;
  logic signed [ACC_W-1:0]   row_accumulator;
  logic [ROWS_W-1:0]         row_counter;
  logic                      sat_seen;
  logic [SCALE_W-1:0]        gscale;
  logic                      last;
  logic signed [GPROD_W-1:0] gprod;
  logic [PLO_W-1:0]          plo;
  logic signed [PLO_W-1:0]   phi;

  // item dot product
  logic signed [PROD_W-1:0]  lane_prod [FIELD_LANES];
  logic signed [DOT_W-1:0]   dot;
  logic signed [PART_W:0]    psum;
  logic signed [PART_W-1:0]  psum_clip;
  logic                      psum_ovf;
  logic                      close;

  always_comb begin
    for (int i = 0; i < FIELD_LANES; i++) begin
      if (i < USED_LANES) begin
        lane_prod[i] = $signed(in_item.activation_lanes[i*ACT_W +: ACT_W]) *
                       $signed(in_item.weight_nibbles[i*WGT_W +: WGT_W]);
      end else begin
        lane_prod[i] = '0;
      end
    end
  end

  always_comb begin
    dot = '0;
    for (int i = 0; i < FIELD_LANES; i++) begin
      dot = dot + DOT_W'(lane_prod[i]);
    end
  end

  assign psum      = (PART_W+1)'(group_partial) + (PART_W+1)'(dot);
  assign psum_ovf  = psum[PART_W] != psum[PART_W-1];
  assign psum_clip = psum_ovf ? (psum[PART_W] ? PART_MIN : PART_MAX) : psum[PART_W-1:0];
  assign close     = (items_in_group == CNT_W'(ITEMS_PER_GROUP - 1)) || in_item.row_last;

  // group close into accumulator
  logic signed [GPROD_W-1:0] gprod_next;
  logic signed [ACC_W:0]     acc_sum;
  logic                      acc_ovf;
  logic signed [ACC_W-1:0]   acc_clip;

  assign gprod_next = group_partial * $signed({1'b0, gscale});
  assign acc_sum    = (ACC_W+1)'(row_accumulator) + (ACC_W+1)'(gprod);
  assign acc_ovf    = acc_sum[ACC_W] != acc_sum[ACC_W-1];
  assign acc_clip   = acc_ovf ? (acc_sum[ACC_W] ? ACC_MIN : ACC_MAX) : acc_sum[ACC_W-1:0];

  // row result: accumulator split in two halves for the scale multiply
  logic signed [PLO_W:0]    phi_full;
  logic signed [FULL_W-1:0] full;
  logic signed [FULL_W-1:0] shifted;
  logic                     res_ovf;
  logic signed [ACC_W-1:0]  res_clip;
  logic [ROWS_W:0]          row_inc;
  logic                     pass_last;

  assign phi_full = $signed(row_accumulator[ACC_W-1:HALF_W]) *
                    $signed({1'b0, activation_scale});
  assign full     = $signed({phi[FULL_W-HALF_W-1:0], {HALF_W{1'b0}}}) +
                    $signed({{(FULL_W-PLO_W){1'b0}}, plo});
  assign shifted  = full >>> SCALE_FRAC_BITS;
  assign res_ovf  = !((&shifted[FULL_W-1:ACC_W-1]) || !(|shifted[FULL_W-1:ACC_W-1]));
  assign res_clip = res_ovf ? (shifted[FULL_W-1] ? ACC_MIN : ACC_MAX) : shifted[ACC_W-1:0];
  assign row_inc  = {1'b0, row_counter} + (ROWS_W+1)'(1);
  // a row count of zero acts like one
  assign pass_last = row_inc >= {1'b0, rows_in_pass};

  assign status.close    = close;
  assign status.last     = last;
  assign status.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      activation_scale <= {SCALE_W{1'b1}};
      rows_in_pass     <= ROWS_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ACTIVATION_SCALE: activation_scale <= cfg_data;
        REG_ROWS_IN_PASS:     rows_in_pass     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_partial   <= '0;
      items_in_group  <= '0;
      row_accumulator <= '0;
      row_counter     <= '0;
      sat_seen        <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (cmd.load) begin
        group_partial  <= psum_clip;
        items_in_group <= close ? '0 : items_in_group + CNT_W'(1);
        if (psum_ovf) sat_seen <= 1'b1;
      end
      if (cmd.gmul) group_partial <= '0;
      if (cmd.gacc) begin
        row_accumulator <= acc_clip;
        if (acc_ovf) sat_seen <= 1'b1;
      end
      if (cmd.fin) begin
        row_accumulator <= '0;
        sat_seen        <= 1'b0;
        row_counter     <= pass_last ? '0 : row_inc[ROWS_W-1:0];
        out_valid       <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      gscale <= in_item.group_scale;
      last   <= in_item.row_last;
    end
    if (cmd.gmul) gprod <= gprod_next;
    if (cmd.mlo)  plo   <= row_accumulator[HALF_W-1:0] * activation_scale;
    if (cmd.mhi)  phi   <= phi_full[PLO_W-1:0];
    if (cmd.fin) begin
      out_item.channel_value <= res_clip;
      out_item.saturated     <= sat_seen || res_ovf;
      out_item.pass_last     <= pass_last;
    end
  end

endmodule

/* src/grouped_int4_int8_gemv_unit.sv */
// After the row's last request is loaded, states GMUL, GACC, MLO, MHI and FIN run; FIN
// writes the output register once the previous result there is no longer stalled.
// Throughput: one request per cycle inside a group; one closing a group stalls the
// input through GMUL and GACC, one closing a row also through MLO, MHI and FIN; set by
// the shared group-scale multiply and the two-pass 48x16 activation-scale multiply.
// Reset (rst, synchronous): row state cleared, activation_scale 65535, rows_in_pass 1.
module grouped_int4_int8_gemv_unit
  import gemv_pkg::*;
#(
  parameter int LANES           = 8,
  parameter int GROUP_SIZE      = 32,
  parameter int SCALE_FRAC_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [SCALE_W-1:0]     cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  gemv_in_t               in_item,
  output logic                   out_valid,
  input  logic                   out_stall,
  output gemv_out_t              out_item
);

  gemv_cmd_t    cmd;
  gemv_status_t status;

  gemv_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  gemv_datapath #(
    .LANES           (LANES),
    .GROUP_SIZE      (GROUP_SIZE),
    .SCALE_FRAC_BITS (SCALE_FRAC_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_item   (in_item),
    .out_item  (out_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

endmodule
